[design/bft_pkg.sv]
package bft_pkg;

    // Filter geometry; the bit count must be a power of two
    localparam int FILTER_BITS = 8192;
    localparam int POS_W       = $clog2(FILTER_BITS);
    localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int BYTE_W      = 8;
    localparam int BIT_SEL_W   = $clog2(BYTE_W);

    // Field and register widths
    localparam int CHAR_W    = 8;
    localparam int SEED_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [SEED_W-1:0] SEED_FIRST_RST  = 32'd17;
    localparam logic [SEED_W-1:0] SEED_SECOND_RST = 32'd29;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_FIRST  = 1'b0,
        CFG_SEED_SECOND = 1'b1
    } cfg_reg_t;

    // Command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_CHECK  = 1'b1
    } cmd_t;

    // Filter controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_WRITE
    } ctrl_state_t;

    // Bit positions of the two hashes after the current character
    typedef struct packed {
        logic [POS_W-1:0] pos_first;
        logic [POS_W-1:0] pos_second;
    } hash_pos_t;

endpackage

[design/bft_ram.sv]
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[design/bft_hash.sv]
module bft_hash import bft_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEED_W-1:0]    cfg_data,
    input  logic                 take,
    input  logic [CHAR_W-1:0]    ch,
    input  logic                 last_char,
    output hash_pos_t            mix
);

    logic [SEED_W-1:0] seed_first_reg, seed_first_next;
    logic [SEED_W-1:0] seed_second_reg, seed_second_next;
    logic [POS_W-1:0]  hash_first_reg, hash_first_next;
    logic [POS_W-1:0]  hash_second_reg, hash_second_next;
    logic              in_string_reg, in_string_next;
    logic [POS_W-1:0]  base_first, base_second;
    logic [63:0]       ch_wide;
    logic [POS_W-1:0]  ch_ext;

    // Seed register writes; a write mid-string only affects the next string
    always_comb
    begin
        seed_first_next  = seed_first_reg;
        seed_second_next = seed_second_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SEED_FIRST:  seed_first_next  = cfg_data;
                CFG_SEED_SECOND: seed_second_next = cfg_data;
                default:         ;
            endcase
        end
    end

    // djb2 step, h*33 + c; only the low POS_W bits reach the position
    always_comb
    begin
        ch_wide     = {{(64 - CHAR_W){ch[CHAR_W-1]}}, ch};
        ch_ext      = ch_wide[POS_W-1:0];
        base_first  = in_string_reg ? hash_first_reg  : seed_first_reg[POS_W-1:0];
        base_second = in_string_reg ? hash_second_reg : seed_second_reg[POS_W-1:0];
        mix.pos_first  = (base_first  << 5) + base_first  + ch_ext;
        mix.pos_second = (base_second << 5) + base_second + ch_ext;
    end

    // Running hash update per transfer
    always_comb
    begin
        hash_first_next  = hash_first_reg;
        hash_second_next = hash_second_reg;
        in_string_next   = in_string_reg;
        if (take)
        begin
            hash_first_next  = mix.pos_first;
            hash_second_next = mix.pos_second;
            in_string_next   = !last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_first_reg  <= SEED_FIRST_RST;
            seed_second_reg <= SEED_SECOND_RST;
            in_string_reg   <= 1'b0;
        end
        else
        begin
            seed_first_reg  <= seed_first_next;
            seed_second_reg <= seed_second_next;
            in_string_reg   <= in_string_next;
        end
    end

    // Hash values are only used while a string is open
    always_ff @(posedge clk)
    begin
        hash_first_reg  <= hash_first_next;
        hash_second_reg <= hash_second_next;
    end

endmodule

[design/bft_ctrl.sv]
module bft_ctrl import bft_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              cmd,
    input  logic              last_char,
    input  hash_pos_t         mix,
    input  logic              out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output logic              hit,
    output logic              op_done,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [BYTE_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0] ram_raddr_a,
    output logic [ADDR_W-1:0] ram_raddr_b,
    input  logic [BYTE_W-1:0] ram_rdata_a,
    input  logic [BYTE_W-1:0] ram_rdata_b
);

    ctrl_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    hash_pos_t         pos_reg, pos_next;
    logic              cmd_reg, cmd_next;
    logic [BYTE_W-1:0] byte_b_reg, byte_b_next;
    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;
    logic              op_done_reg, op_done_next;
    logic              out_free;
    logic              out_load;
    logic              same_byte;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [BIT_SEL_W-1:0] sel_a, sel_b;
    logic [BYTE_W-1:0] mask_a, mask_b;

    // Byte address and bit mask of each position
    always_comb
    begin
        addr_a    = pos_reg.pos_first[POS_W-1:BIT_SEL_W];
        addr_b    = pos_reg.pos_second[POS_W-1:BIT_SEL_W];
        sel_a     = pos_reg.pos_first[BIT_SEL_W-1:0];
        sel_b     = pos_reg.pos_second[BIT_SEL_W-1:0];
        mask_a    = BYTE_W'(1) << sel_a;
        mask_b    = BYTE_W'(1) << sel_b;
        same_byte = (addr_a == addr_b);
    end

    assign out_free    = !out_valid_reg || !out_stall;
    assign ram_raddr_a = addr_a;
    assign ram_raddr_b = addr_b;

    // Sequencer: clear pass, accept, read, modify, write back
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pos_next     = pos_reg;
        cmd_next     = cmd_reg;
        byte_b_next  = byte_b_reg;
        in_stall     = 1'b1;
        ram_we       = 1'b0;
        ram_waddr    = addr_a;
        ram_wdata    = '0;
        out_load     = 1'b0;
        hit_next     = hit_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (take && last_char)
                begin
                    pos_next   = mix;
                    cmd_next   = cmd;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (cmd_t'(cmd_reg) == CMD_CHECK)
                begin
                    // read ports hold their address, so data stays put while waiting
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        hit_next   = ram_rdata_a[sel_a] & ram_rdata_b[sel_b];
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // set first bit; merge second when both share a byte
                    ram_we      = 1'b1;
                    ram_waddr   = addr_a;
                    ram_wdata   = ram_rdata_a | mask_a | (same_byte ? mask_b : '0);
                    byte_b_next = ram_rdata_b | mask_b | (same_byte ? mask_a : '0);
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_b;
                ram_wdata = byte_b_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    hit_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        op_done_next   = op_done_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            op_done_next   = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cmd_reg     <= cmd_next;
        byte_b_reg  <= byte_b_next;
        hit_reg     <= hit_next;
        op_done_reg <= op_done_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign op_done   = op_done_reg;

endmodule

[design/bloom_filter_two_hash.sv]
// Bloom filter over byte strings, one character per input transfer, with two
// djb2 hashes (h*33 + c, bytes sign-extended) started from seed_first and
// seed_second at each string's first character. The filter sits in a
// 1024 x 8 RAM with one write port and two registered read ports. After
// reset a clearing pass zeroes the RAM, one byte per cycle; in_stall stays
// high until it ends, configuration writes are taken as always. A non-final
// character only updates the running hashes and leaves in_stall low. A final
// character steps through accept, RAM read, modify/first write-back and, for
// insert, second write-back, set by the registered RAM reads and the single
// RAM write port; a check skips the second write-back. Results wait in an
// output register while out_stall is high. Seeds may be written at any time
// and apply from the next string. The filter bit count is a power of two.
module bloom_filter_two_hash import bft_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEED_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [CHAR_W-1:0]    ch,
    input  logic                 last_char,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic                 op_done
);

    logic              take;
    hash_pos_t         mix;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [BYTE_W-1:0] ram_rdata_a;
    logic [BYTE_W-1:0] ram_rdata_b;

    // Input transfer
    assign take = in_valid && !in_stall;

    bft_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .ch        (ch),
        .last_char (last_char),
        .mix       (mix)
    );

    bft_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .cmd         (cmd),
        .last_char   (last_char),
        .mix         (mix),
        .out_stall   (out_stall),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .hit         (hit),
        .op_done     (op_done),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b)
    );

    bft_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_filter_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

endmodule

[design/bft_checker.sv]
module bft_checker import bft_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [SEED_W-1:0]    cfg_data,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 cmd,
    input logic [CHAR_W-1:0]    ch,
    input logic                 last_char,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 hit,
    input logic                 op_done
);

    // Held result stays unchanged while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(op_done))
        else $error("result changed while stalled");

    // Every result marks a finished string
    a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> op_done)
        else $error("result without op_done");

    // Final character blocks input while the filter is updated
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_char |=> in_stall)
        else $error("input taken during filter access");

    // A new result only comes out of filter processing, never straight from input
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without preceding filter access");

    // Clearing pass holds off input right after reset
    a_clear_stall: assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall)
        else $error("input open during clearing pass");

endmodule

bind bloom_filter_two_hash bft_checker u_bft_checker (.*);
